/* hw/rtl/bfs_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the breadth-first search block.
// No dependencies.
package bfs_pkg;

    localparam int MAX_VERTICES_DEF = 64;
    localparam int MAX_EDGES_DEF    = 256;
    localparam int VW               = 6;
    localparam int CW               = 7;

    localparam logic [1:0] OP_ADD   = 2'd0;
    localparam logic [1:0] OP_CLEAR = 2'd1;
    localparam logic [1:0] OP_RUN   = 2'd2;
    localparam logic [1:0] OP_NOP   = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    localparam logic [6:0] UNREACHED = 7'h7F;

    typedef struct packed {
        logic [1:0]    op;
        logic [VW-1:0] vertex_a;
        logic [VW-1:0] vertex_b;
    } in_item_t;

    typedef struct packed {
        logic [VW-1:0] vertex;
        logic [VW-1:0] distance;
        logic          reachable;
        logic [VW-1:0] predecessor;
        logic          has_predecessor;
        logic [1:0]    status;
        logic          last;
    } out_item_t;

    // hop count (7 bits) and parent link (valid bit over 6-bit vertex)
    typedef struct packed {
        logic [6:0] hops;
        logic [6:0] link;
    } vert_entry_t;

endpackage

/* hw/rtl/bfs_unweighted_shortest_path_top.sv */
`timescale 1ns / 1ps
// Breadth-first shortest-path engine: control, visit queue, output register.
// Depends on bfs_pkg, bfs_edge_mem, bfs_vert_mem.
// Add-edge and clear items: result valid in the cycle after the item is taken; one item
// per cycle while the output register is free. Search item: reset the N vertex entries,
// seed the source, then per dequeued vertex read its distance and scan every stored edge,
// visit-check each hit; on an empty queue emit one result per vertex (N = vertex_count).
// Search time is set by the single read port of the edge store.
// Reset: edge count 0, vertex_count MAX_VERTICES, no result pending.
module bfs_unweighted_shortest_path_top #(
    parameter int MAX_VERTICES = bfs_pkg::MAX_VERTICES_DEF,
    parameter int MAX_EDGES    = bfs_pkg::MAX_EDGES_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [6:0]          cfg_data,
    input  logic                in_valid,
    output logic                in_ready,
    input  bfs_pkg::in_item_t   in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output bfs_pkg::out_item_t  out_data
);
    import bfs_pkg::*;

    localparam int VAW = $clog2(MAX_VERTICES);
    localparam int QCW = $clog2(MAX_VERTICES + 1);
    localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int ETW = $clog2(MAX_EDGES + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_CLEAR, S_SEED, S_DEQ, S_DEQ_WAIT, S_DIST_WAIT,
        S_SCAN_RD, S_SCAN_CHK, S_VIS_CHK, S_EMIT_RD, S_EMIT_WR
    } state_t;

    state_t          state_reg;
    logic [CW-1:0]   vcount_reg;
    logic [ETW-1:0]  etotal_reg;
    logic [ETW-1:0]  e_reg;
    logic [QCW-1:0]  head_reg;
    logic [QCW-1:0]  tail_reg;
    logic [CW-1:0]   idx_reg;
    logic [VW-1:0]   src_reg;
    logic [VW-1:0]   v_reg;
    logic [VW-1:0]   dst_reg;
    logic [6:0]      dv_reg;
    logic            out_valid_reg;
    logic            out_valid_next;
    out_item_t       out_data_reg;

    logic [VW-1:0]   queue [MAX_VERTICES];
    logic [VW-1:0]   q_rdata;
    logic            q_we;
    logic [VAW-1:0]  q_waddr;
    logic [VW-1:0]   q_wdata;

    logic            e_we;
    logic [EAW-1:0]  e_raddr;
    logic [2*VW-1:0] e_rdata;
    logic            v_we;
    logic [VAW-1:0]  v_waddr;
    vert_entry_t     v_wdata;
    logic [VAW-1:0]  v_raddr;
    vert_entry_t     v_rdata;

    logic            accept;
    logic            out_free;
    logic            out_set;
    logic            add_range_err;
    logic            run_range_err;
    logic            add_full;
    logic [1:0]      idle_status;
    logic [VW-1:0]   e_src;
    logic [VW-1:0]   e_dst;
    logic            e_hit;
    logic            e_done;
    logic            discover;
    logic [CW-1:0]   cfg_clamped;

    assign out_free  = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == S_IDLE) && out_free;
    assign accept    = in_valid && in_ready;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign add_range_err = ({1'b0, in_data.vertex_a} >= vcount_reg)
                        || ({1'b0, in_data.vertex_b} >= vcount_reg);
    assign run_range_err = {1'b0, in_data.vertex_a} >= vcount_reg;
    assign add_full      = etotal_reg >= ETW'(MAX_EDGES);
    assign e_src         = e_rdata[VW-1:0];
    assign e_dst         = e_rdata[2*VW-1:VW];
    assign e_hit         = (e_src == v_reg) && ({1'b0, e_dst} < vcount_reg);
    assign e_done        = (e_reg + ETW'(1)) >= etotal_reg;
    assign discover      = (v_rdata.hops == UNREACHED) && (tail_reg < QCW'(MAX_VERTICES));

    assign out_set = (accept && (in_data.op != OP_NOP)
                      && !((in_data.op == OP_RUN) && !run_range_err))
                  || (state_reg == S_EMIT_WR);
    assign out_valid_next = out_set || (out_valid_reg && !out_ready);

    always_comb
    begin
        idle_status = ST_OK;
        case (in_data.op)
            OP_ADD:
            begin
                if (add_range_err)
                begin
                    idle_status = ST_RANGE;
                end
                else if (add_full)
                begin
                    idle_status = ST_FULL;
                end
            end
            OP_RUN:
            begin
                if (run_range_err)
                begin
                    idle_status = ST_RANGE;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        if (cfg_data == '0)
        begin
            cfg_clamped = CW'(1);
        end
        else if (cfg_data > CW'(MAX_VERTICES))
        begin
            cfg_clamped = CW'(MAX_VERTICES);
        end
        else
        begin
            cfg_clamped = cfg_data;
        end
    end

    // memory controls
    always_comb
    begin
        e_we    = accept && (in_data.op == OP_ADD) && !add_range_err && !add_full;
        e_raddr = e_reg[EAW-1:0];
        v_we    = 1'b0;
        v_waddr = idx_reg[VAW-1:0];
        v_wdata = '{hops: UNREACHED, link: 7'd0};
        v_raddr = v_reg[VAW-1:0];
        q_we    = 1'b0;
        q_waddr = tail_reg[VAW-1:0];
        q_wdata = dst_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                v_we = 1'b1;
            end
            S_SEED:
            begin
                v_we    = 1'b1;
                v_waddr = src_reg[VAW-1:0];
                v_wdata = '{hops: 7'd0, link: 7'd0};
                q_we    = 1'b1;
                q_waddr = '0;
                q_wdata = src_reg;
            end
            S_DEQ_WAIT:
            begin
                v_raddr = q_rdata[VAW-1:0];
            end
            S_SCAN_CHK:
            begin
                v_raddr = e_dst[VAW-1:0];
            end
            S_VIS_CHK:
            begin
                v_we    = discover;
                v_waddr = dst_reg[VAW-1:0];
                v_wdata = '{hops: dv_reg + 7'd1, link: {1'b1, v_reg}};
                q_we    = discover;
            end
            S_EMIT_RD:
            begin
                v_raddr = idx_reg[VAW-1:0];
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (q_we)
        begin
            queue[q_waddr] <= q_wdata;
        end
        q_rdata <= queue[head_reg[VAW-1:0]];
    end

    bfs_edge_mem #(
        .MAX_EDGES (MAX_EDGES),
        .EAW       (EAW)
    ) u_edge_mem (
        .clk   (clk),
        .we    (e_we),
        .waddr (etotal_reg[EAW-1:0]),
        .wdata ({in_data.vertex_b, in_data.vertex_a}),
        .raddr (e_raddr),
        .rdata (e_rdata)
    );

    bfs_vert_mem #(
        .MAX_VERTICES (MAX_VERTICES),
        .VAW          (VAW)
    ) u_vert_mem (
        .clk   (clk),
        .we    (v_we),
        .waddr (v_waddr),
        .wdata (v_wdata),
        .raddr (v_raddr),
        .rdata (v_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            vcount_reg    <= CW'(MAX_VERTICES);
            etotal_reg    <= '0;
            e_reg         <= '0;
            head_reg      <= '0;
            tail_reg      <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                vcount_reg <= cfg_clamped;
            end
            out_valid_reg <= out_valid_next;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        out_data_reg <= '{vertex: '0, distance: '0, reachable: 1'b0,
                                          predecessor: '0, has_predecessor: 1'b0,
                                          status: idle_status, last: 1'b1};
                        src_reg <= in_data.vertex_a;
                        case (in_data.op)
                            OP_ADD:
                            begin
                                if (!add_range_err && !add_full)
                                begin
                                    etotal_reg <= etotal_reg + ETW'(1);
                                end
                            end
                            OP_CLEAR:
                            begin
                                etotal_reg <= '0;
                            end
                            OP_RUN:
                            begin
                                if (!run_range_err)
                                begin
                                    idx_reg   <= '0;
                                    state_reg <= S_CLEAR;
                                end
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
                S_CLEAR:
                begin
                    idx_reg <= idx_reg + CW'(1);
                    if (idx_reg + CW'(1) == vcount_reg)
                    begin
                        state_reg <= S_SEED;
                    end
                end
                S_SEED:
                begin
                    head_reg  <= '0;
                    tail_reg  <= QCW'(1);
                    state_reg <= S_DEQ;
                end
                S_DEQ:
                begin
                    if (head_reg == tail_reg)
                    begin
                        idx_reg   <= '0;
                        state_reg <= S_EMIT_RD;
                    end
                    else
                    begin
                        head_reg  <= head_reg + QCW'(1);
                        state_reg <= S_DEQ_WAIT;
                    end
                end
                S_DEQ_WAIT:
                begin
                    v_reg     <= q_rdata;
                    state_reg <= S_DIST_WAIT;
                end
                S_DIST_WAIT:
                begin
                    dv_reg <= v_rdata.hops;
                    e_reg  <= '0;
                    if (etotal_reg == '0)
                    begin
                        state_reg <= S_DEQ;
                    end
                    else
                    begin
                        state_reg <= S_SCAN_RD;
                    end
                end
                S_SCAN_RD:
                begin
                    state_reg <= S_SCAN_CHK;
                end
                S_SCAN_CHK:
                begin
                    dst_reg <= e_dst;
                    if (e_hit)
                    begin
                        state_reg <= S_VIS_CHK;
                    end
                    else
                    begin
                        e_reg     <= e_reg + ETW'(1);
                        state_reg <= e_done ? S_DEQ : S_SCAN_RD;
                    end
                end
                S_VIS_CHK:
                begin
                    if (discover)
                    begin
                        tail_reg <= tail_reg + QCW'(1);
                    end
                    e_reg     <= e_reg + ETW'(1);
                    state_reg <= e_done ? S_DEQ : S_SCAN_RD;
                end
                S_EMIT_RD:
                begin
                    if (out_free)
                    begin
                        state_reg <= S_EMIT_WR;
                    end
                end
                S_EMIT_WR:
                begin
                    out_data_reg.vertex <= idx_reg[VW-1:0];
                    out_data_reg.status <= ST_OK;
                    if (v_rdata.hops != UNREACHED)
                    begin
                        out_data_reg.distance  <= v_rdata.hops[VW-1:0];
                        out_data_reg.reachable <= 1'b1;
                    end
                    else
                    begin
                        out_data_reg.distance  <= '0;
                        out_data_reg.reachable <= 1'b0;
                    end
                    out_data_reg.has_predecessor <= v_rdata.link[6];
                    out_data_reg.predecessor <= v_rdata.link[6] ? v_rdata.link[VW-1:0] : '0;
                    out_data_reg.last <= (idx_reg + CW'(1)) == vcount_reg;
                    idx_reg <= idx_reg + CW'(1);
                    if ((idx_reg + CW'(1)) == vcount_reg)
                    begin
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        state_reg <= S_EMIT_RD;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

/* hw/rtl/bfs_edge_mem.sv */
`timescale 1ns / 1ps
// Edge store: one write port, one registered read port.
// Depends on bfs_pkg.
module bfs_edge_mem #(
    parameter int MAX_EDGES = bfs_pkg::MAX_EDGES_DEF,
    parameter int EAW       = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1
) (
    input  logic                      clk,
    input  logic                      we,
    input  logic [EAW-1:0]            waddr,
    input  logic [2*bfs_pkg::VW-1:0]  wdata,
    input  logic [EAW-1:0]            raddr,
    output logic [2*bfs_pkg::VW-1:0]  rdata
);
    import bfs_pkg::*;

    logic [2*VW-1:0] mem [MAX_EDGES];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* hw/rtl/bfs_vert_mem.sv */
`timescale 1ns / 1ps
// Per-vertex distance and parent link store, registered read.
// Depends on bfs_pkg.
module bfs_vert_mem #(
    parameter int MAX_VERTICES = bfs_pkg::MAX_VERTICES_DEF,
    parameter int VAW          = $clog2(MAX_VERTICES)
) (
    input  logic                  clk,
    input  logic                  we,
    input  logic [VAW-1:0]        waddr,
    input  bfs_pkg::vert_entry_t  wdata,
    input  logic [VAW-1:0]        raddr,
    output bfs_pkg::vert_entry_t  rdata
);
    import bfs_pkg::*;

    vert_entry_t mem [MAX_VERTICES];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
